// File: hw/rtl/mct_pkg.sv
`timescale 1ns / 1ps

package mct_pkg;

	// Time field limits
	localparam logic [6:0]  MAX_MINUTES   = 7'd99;
	localparam logic [5:0]  SECONDS_LAST  = 6'd59;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

	// Register reset values
	localparam logic [6:0]  START_MIN_RST = 7'd5;
	localparam logic [15:0] HOLD_MS_RST   = 16'd2000;
	localparam logic [15:0] SECOND_MS_RST = 16'd1000;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_START_MINUTES = 2'd0;
	localparam logic [1:0] CFG_HOLD_MS       = 2'd1;
	localparam logic [1:0] CFG_SECOND_MS     = 2'd2;

	typedef enum logic [1:0] {
		MODE_SETTING  = 2'd0,
		MODE_RUNNING  = 2'd1,
		MODE_PAUSED   = 2'd2,
		MODE_FINISHED = 2'd3
	} mode_t;

	typedef struct packed {
		logic [6:0]  start_minutes;
		logic [15:0] hold_ms;
		logic [15:0] second_ms;
	} cfg_t;

	typedef struct packed {
		logic ms_tick;
		logic right_held;
		logic up_press;
		logic down_press;
		logic right_press;
	} in_word_t;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  minutes;
		logic [5:0]  seconds;
		logic        edit_sec;
		logic [15:0] hold_cnt;
		logic [15:0] tick_cnt;
	} timer_state_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] c);
		sat_inc = (c == COUNT_MAX) ? c : c + 16'd1;
	endfunction

endpackage

// File: hw/rtl/mct_cfg_regs.sv
`timescale 1ns / 1ps

module mct_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output mct_pkg::cfg_t   cfg
);

	mct_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_minutes <= mct_pkg::START_MIN_RST;
			cfg_q.hold_ms       <= mct_pkg::HOLD_MS_RST;
			cfg_q.second_ms     <= mct_pkg::SECOND_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mct_pkg::CFG_START_MINUTES: cfg_q.start_minutes <= cfg_data[6:0];
				mct_pkg::CFG_HOLD_MS:       cfg_q.hold_ms       <= cfg_data;
				mct_pkg::CFG_SECOND_MS:     cfg_q.second_ms     <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/mct_in_reg.sv
`timescale 1ns / 1ps

module mct_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mct_pkg::in_word_t   in_word,
	input  logic                fire,
	output logic                in_stall,
	output logic                valid_s1,
	output mct_pkg::in_word_t   word_s1
);

	logic accept;

	// stage holds while its word cannot move on
	assign in_stall = valid_s1 && !fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

endmodule

// File: hw/rtl/mct_core.sv
`timescale 1ns / 1ps

module mct_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  mct_pkg::in_word_t     word_s1,
	input  mct_pkg::cfg_t         cfg,
	output mct_pkg::timer_state_t cur_state,
	output mct_pkg::timer_state_t nxt_state
);

	mct_pkg::timer_state_t state_q;
	mct_pkg::timer_state_t nxt;
	logic [6:0]            reload_min;
	logic [15:0]           hold_inc;
	logic [15:0]           tick_inc;

	assign reload_min = (cfg.start_minutes > mct_pkg::MAX_MINUTES) ?
		mct_pkg::MAX_MINUTES : cfg.start_minutes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode     <= mct_pkg::MODE_SETTING;
			state_q.minutes  <= mct_pkg::START_MIN_RST;
			state_q.seconds  <= '0;
			state_q.edit_sec <= 1'b0;
			state_q.hold_cnt <= '0;
			state_q.tick_cnt <= '0;
		end else if (fire) begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt      = state_q;
		hold_inc = '0;
		tick_inc = '0;

		// long press on right forces a reload before the mode logic
		if (word_s1.right_held) begin
			hold_inc = word_s1.ms_tick ? mct_pkg::sat_inc(state_q.hold_cnt) :
				state_q.hold_cnt;
			if (hold_inc >= cfg.hold_ms) begin
				nxt.mode     = mct_pkg::MODE_SETTING;
				nxt.minutes  = reload_min;
				nxt.seconds  = '0;
				nxt.edit_sec = 1'b0;
				nxt.hold_cnt = '0;
			end else begin
				nxt.hold_cnt = hold_inc;
			end
		end else begin
			nxt.hold_cnt = '0;
		end

		unique case (nxt.mode)
			mct_pkg::MODE_SETTING: begin
				if (word_s1.up_press) begin
					if (!nxt.edit_sec) begin
						if (nxt.minutes < mct_pkg::MAX_MINUTES)
							nxt.minutes = nxt.minutes + 7'd1;
					end else begin
						nxt.seconds = (nxt.seconds >= mct_pkg::SECONDS_LAST) ?
							6'd0 : nxt.seconds + 6'd1;
					end
				end
				if (word_s1.down_press)
					nxt.edit_sec = !nxt.edit_sec;
				if (word_s1.right_press && (nxt.minutes != '0 || nxt.seconds != '0)) begin
					nxt.mode     = mct_pkg::MODE_RUNNING;
					nxt.tick_cnt = '0;
				end
			end
			mct_pkg::MODE_RUNNING: begin
				tick_inc = word_s1.ms_tick ? mct_pkg::sat_inc(nxt.tick_cnt) :
					nxt.tick_cnt;
				if (tick_inc >= cfg.second_ms) begin
					if (nxt.seconds != '0) begin
						nxt.seconds = nxt.seconds - 6'd1;
					end else if (nxt.minutes != '0) begin
						nxt.minutes = nxt.minutes - 7'd1;
						nxt.seconds = mct_pkg::SECONDS_LAST;
					end
					nxt.tick_cnt = '0;
					if (nxt.minutes == '0 && nxt.seconds == '0)
						nxt.mode = mct_pkg::MODE_FINISHED;
				end else begin
					nxt.tick_cnt = tick_inc;
				end
				// right wins over a finish in the same pass
				if (word_s1.right_press)
					nxt.mode = mct_pkg::MODE_PAUSED;
			end
			mct_pkg::MODE_PAUSED: begin
				if (word_s1.right_press) begin
					nxt.mode     = mct_pkg::MODE_RUNNING;
					nxt.tick_cnt = '0;
				end
			end
			mct_pkg::MODE_FINISHED: begin
				if (word_s1.right_press) begin
					nxt.mode     = mct_pkg::MODE_SETTING;
					nxt.minutes  = reload_min;
					nxt.seconds  = '0;
					nxt.edit_sec = 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign cur_state = state_q;
	assign nxt_state = nxt;

endmodule

// File: hw/rtl/mmss_countdown_timer.sv
`timescale 1ns / 1ps

// Minutes:seconds countdown timer.
// Input channel (in_valid / in_stall): one word per control-loop pass, carrying
// the millisecond tick, the right-button level and the up/down/right press events.
// Output channel (out_valid / out_stall): one word per input word, holding the
// time, mode and selected field as they stand after that pass.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 start minutes,
// 1 hold time in ticks, 2 ticks per second; other indexes are dropped. Write only
// while no word is in flight.
// A taken word sits in the input register; once the result register is free, the
// state update runs on it and loads the result register, which raises out_valid.
// Throughput: one word per cycle while the result register is not stalled.
// A stalled result holds in the output register; the input register keeps taking
// one more word, then in_stall rises until the output frees up.
// Reset: registers return to 5 min / 2000 / 1000, time 05:00 in setting mode
// with minutes selected, both counters cleared, both channels empty.

module mmss_countdown_timer (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        ms_tick,
	input  logic        right_held,
	input  logic        up_press,
	input  logic        down_press,
	input  logic        right_press,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  shown_minutes,
	output logic [5:0]  shown_seconds,
	output logic [1:0]  mode,
	output logic        editing_seconds,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	mct_pkg::cfg_t         cfg;
	mct_pkg::in_word_t     in_word;
	mct_pkg::in_word_t     word_s1;
	mct_pkg::timer_state_t cur_state;
	mct_pkg::timer_state_t nxt_state;
	logic                  valid_s1;
	logic                  fire;
	logic                  out_valid_q;

	assign cfg_ready = 1'b1;

	assign in_word.ms_tick     = ms_tick;
	assign in_word.right_held  = right_held;
	assign in_word.up_press    = up_press;
	assign in_word.down_press  = down_press;
	assign in_word.right_press = right_press;

	// stage-1 word moves into the result register when that is free
	assign fire = valid_s1 && (!out_valid_q || !out_stall);

	mct_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mct_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_word  (in_word),
		.fire     (fire),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	mct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.word_s1   (word_s1),
		.cfg       (cfg),
		.cur_state (cur_state),
		.nxt_state (nxt_state)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			shown_minutes   <= nxt_state.minutes;
			shown_seconds   <= nxt_state.seconds;
			mode            <= nxt_state.mode;
			editing_seconds <= nxt_state.edit_sec;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("result word missing after state update");

	a_seconds_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_state.seconds <= mct_pkg::SECONDS_LAST)
		else $error("seconds count out of range");

	a_minutes_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_state.minutes <= mct_pkg::MAX_MINUTES)
		else $error("minutes count out of range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled with room downstream");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(cur_state))
		else $error("timer state changed without a word");
`endif

endmodule

// File: dv/mmss_countdown_timer_test.sv
`timescale 1ns / 1ps

module mmss_countdown_timer_test;

	import mct_pkg::*;

	// index 3 decodes to no register and must be dropped
	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam int         CYCLE_LIMIT = 1000000;
	localparam int         PRINT_CAP   = 100;

	// one shown time as the block should present it after a word
	typedef struct packed {
		logic [6:0] mins;
		logic [5:0] secs;
		mode_t      mode;
		logic       edit_sec;
	} shown_t;

	// local copy of the timer state
	typedef struct {
		mode_t       mode;
		logic [6:0]  mins;
		logic [5:0]  secs;
		logic        edit_sec;
		logic [15:0] hold_cnt;
		logic [15:0] tick_cnt;
	} timer_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        ms_tick = 1'b0;
	logic        right_held = 1'b0;
	logic        up_press = 1'b0;
	logic        down_press = 1'b0;
	logic        right_press = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  shown_minutes;
	logic [5:0]  shown_seconds;
	logic [1:0]  mode;
	logic        editing_seconds;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	mmss_countdown_timer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.ms_tick         (ms_tick),
		.right_held      (right_held),
		.up_press        (up_press),
		.down_press      (down_press),
		.right_press     (right_press),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.shown_minutes   (shown_minutes),
		.shown_seconds   (shown_seconds),
		.mode            (mode),
		.editing_seconds (editing_seconds),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// 4 ns period
	initial begin
		forever #2 clk = ~clk;
	end

	// register mirror and timer state, owned by the predictor
	logic [6:0]  start_min_reg;
	logic [15:0] hold_ticks_reg;
	logic [15:0] second_ticks_reg;
	timer_t      tmr;

	in_word_t pending_words[$];     // words waiting for the driver
	shown_t   expected_display[$];  // one entry per accepted word, oldest first

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int words_queued   = 0;
	int cycle_count    = 0;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [15:0] bump_sat(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	// reload: start minutes (clamped), zero seconds, minutes field, setting mode.
	// tick_cnt is deliberately left alone.
	function automatic void reload_timer();
		tmr.mode     = MODE_SETTING;
		tmr.mins     = (start_min_reg > MAX_MINUTES) ? MAX_MINUTES : start_min_reg;
		tmr.secs     = '0;
		tmr.edit_sec = 1'b0;
	endfunction

	function automatic void reset_timer();
		start_min_reg    = START_MIN_RST;
		hold_ticks_reg   = HOLD_MS_RST;
		second_ticks_reg = SECOND_MS_RST;
		reload_timer();
		tmr.hold_cnt = '0;
		tmr.tick_cnt = '0;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] data);
		case (idx)
			CFG_START_MINUTES: start_min_reg = data[6:0];
			CFG_HOLD_MS:       hold_ticks_reg = data;
			CFG_SECOND_MS:     second_ticks_reg = data;
			default: ;
		endcase
	endfunction

	// advance the timer by one control-loop word and return what it shows
	function automatic shown_t step_timer(input in_word_t w);
		shown_t s;
		// hold check comes first; the mode logic then sees its outcome
		if (w.right_held) begin
			if (w.ms_tick)
				tmr.hold_cnt = bump_sat(tmr.hold_cnt);
			if (tmr.hold_cnt >= hold_ticks_reg) begin
				reload_timer();
				tmr.hold_cnt = '0;
			end
		end else begin
			tmr.hold_cnt = '0;
		end

		case (tmr.mode)
			MODE_SETTING: begin
				// order: up, down, right
				if (w.up_press) begin
					if (!tmr.edit_sec) begin
						if (tmr.mins < MAX_MINUTES)
							tmr.mins = tmr.mins + 7'd1;
					end else begin
						tmr.secs = (tmr.secs >= SECONDS_LAST) ? 6'd0 : tmr.secs + 6'd1;
					end
				end
				if (w.down_press)
					tmr.edit_sec = ~tmr.edit_sec;
				if (w.right_press && (tmr.mins != 0 || tmr.secs != 0)) begin
					tmr.mode     = MODE_RUNNING;
					tmr.tick_cnt = '0;
				end
			end
			MODE_RUNNING: begin
				if (w.ms_tick)
					tmr.tick_cnt = bump_sat(tmr.tick_cnt);
				if (tmr.tick_cnt >= second_ticks_reg) begin
					if (tmr.secs != 0) begin
						tmr.secs = tmr.secs - 6'd1;
					end else if (tmr.mins != 0) begin
						tmr.mins = tmr.mins - 7'd1;
						tmr.secs = SECONDS_LAST;
					end
					tmr.tick_cnt = '0;
					if (tmr.mins == 0 && tmr.secs == 0)
						tmr.mode = MODE_FINISHED;
				end
				// a press on the finishing word still pauses
				if (w.right_press)
					tmr.mode = MODE_PAUSED;
			end
			MODE_PAUSED: begin
				if (w.right_press) begin
					tmr.mode     = MODE_RUNNING;
					tmr.tick_cnt = '0;
				end
			end
			default: begin
				if (w.right_press)
					reload_timer();
			end
		endcase

		s.mins     = tmr.mins;
		s.secs     = tmr.secs;
		s.mode     = tmr.mode;
		s.edit_sec = tmr.edit_sec;
		return s;
	endfunction

	// ---------------------------------------------------------------
	// Mismatch reporting
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------
	// Driver: pops pending words, holds a stalled word steady, and
	// predicts each word at the edge that accepts it.
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : word_driver
		in_word_t w;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			ms_tick     <= 1'b0;
			right_held  <= 1'b0;
			up_press    <= 1'b0;
			down_press  <= 1'b0;
			right_press <= 1'b0;
			reset_timer();
		end else begin
			if (in_valid && !in_stall) begin
				w = in_word_t'({ms_tick, right_held, up_press, down_press, right_press});
				expected_display.push_back(step_timer(w));
			end
			// only move on when the current word has gone (or there is none)
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					w = pending_words.pop_front();
					in_valid    <= 1'b1;
					ms_tick     <= w.ms_tick;
					right_held  <= w.right_held;
					up_press    <= w.up_press;
					down_press  <= w.down_press;
					right_press <= w.right_press;
				end else begin
					// idle: payload is free to wander
					in_valid <= 1'b0;
					{ms_tick, right_held, up_press, down_press, right_press} <= 5'($urandom);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, field-by-field compare on accept.
	// ---------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : result_monitor
		shown_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_display.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_display.pop_front();
					if (shown_minutes !== want.mins)
						report_mismatch($sformatf("shown_minutes %0d, want %0d",
							shown_minutes, want.mins));
					if (shown_seconds !== want.secs)
						report_mismatch($sformatf("shown_seconds %0d, want %0d",
							shown_seconds, want.secs));
					if (mode !== want.mode)
						report_mismatch($sformatf("mode %0d, want %s", mode, want.mode.name()));
					if (editing_seconds !== want.edit_sec)
						report_mismatch($sformatf("editing_seconds %0b, want %0b",
							editing_seconds, want.edit_sec));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	task automatic push_word(input bit tick, input bit held, input bit up,
		input bit down, input bit right);
		pending_words.push_back(in_word_t'({tick, held, up, down, right}));
		words_queued++;
	endtask

	// nothing queued, nothing in flight, nothing owed
	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_display.size() != 0)
			@(negedge clk);
	endtask

	// config writes only happen once the timer is drained
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] smin, input logic [15:0] hold,
		input logic [15:0] sec);
		write_reg(CFG_START_MINUTES, smin);
		write_reg(CFG_HOLD_MS, hold);
		write_reg(CFG_SECOND_MS, sec);
	endtask

	// a plausible user session: edit, start, let it run, then press right
	task automatic queue_session();
		int n_up;
		int run_len;
		if ($urandom_range(1) == 1)
			push_word(0, 0, 0, 1, 0);
		// now and then walk the seconds field all the way round
		n_up = ($urandom_range(7) == 0) ? $urandom_range(58, 62) : $urandom_range(0, 3);
		repeat (n_up)
			push_word(1'($urandom_range(1)), 0, 1, 0, 0);
		push_word(0, 0, 0, 0, 1);
		run_len = $urandom_range(2, 40);
		repeat (run_len)
			push_word($urandom_range(3) != 0, 0, 0, 0, $urandom_range(19) == 0);
		push_word(1, 0, 0, 0, 1);
	endtask

	// unstructured words, with the right button held in bursts
	task automatic queue_noise(input int n);
		int burst;
		burst = 0;
		repeat (n) begin
			if (burst == 0 && $urandom_range(99) < 10)
				burst = $urandom_range(1, 16);
			push_word($urandom_range(99) < 75, burst != 0, $urandom_range(99) < 15,
				$urandom_range(99) < 10, $urandom_range(99) < 12);
			if (burst != 0)
				burst--;
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------

	initial begin : stimulus
		int base;
		int phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// -- directed, reset registers (05:00, 2000, 1000)
		push_word(0, 0, 0, 0, 0);
		push_word(1, 0, 1, 0, 0);   // minutes up
		push_word(0, 0, 0, 1, 0);   // select seconds
		push_word(0, 0, 1, 0, 0);   // seconds up
		push_word(0, 0, 1, 1, 0);   // up acts before the toggle
		push_word(1, 0, 0, 0, 1);   // start
		push_word(1, 1, 0, 0, 1);   // pause, hold counting
		push_word(0, 0, 0, 0, 1);   // resume
		wait_drained();

		// -- directed, short times: forced reload, zero-time start refused,
		// finish, reload from finished, finish and pause on one word
		write_all(16'd0, 16'd2, 16'd1);
		push_word(1, 1, 0, 0, 0);
		push_word(1, 1, 0, 0, 0);   // hold reaches limit: reload to 00:00
		push_word(0, 0, 0, 0, 1);   // 00:00 must not start
		push_word(0, 0, 0, 1, 0);
		push_word(0, 0, 1, 0, 1);   // 00:01 and start
		push_word(1, 0, 0, 0, 0);   // reaches zero: finished
		push_word(0, 0, 0, 0, 1);   // reload from finished
		push_word(0, 0, 0, 1, 0);
		push_word(0, 0, 1, 0, 1);
		push_word(1, 0, 0, 0, 1);   // finishes and pauses in the same word
		push_word(0, 0, 0, 0, 1);   // resume at 00:00
		push_word(1, 0, 0, 0, 0);
		wait_drained();

		// -- directed: start minutes over the limit, zero hold, zero second,
		// and a write to the spare index that must change nothing
		write_all(16'hFFFF, 16'd0, 16'd0);
		write_reg(CFG_SPARE, 16'hFFFF);
		push_word(0, 1, 0, 0, 0);   // held with no tick still reloads: 99:00
		push_word(0, 0, 1, 0, 1);   // up stops at the limit; start
		push_word(0, 0, 0, 0, 0);   // every running word is a second
		push_word(0, 0, 0, 0, 1);
		push_word(0, 1, 0, 0, 0);
		wait_drained();

		// -- longer counts: one full countdown second, then one full hold
		write_all(16'd1, 16'd1, 16'd20);
		push_word(1, 1, 0, 0, 0);
		push_word(0, 0, 0, 0, 1);
		repeat (20)
			push_word(1, 0, 0, 0, 0);
		wait_drained();
		write_reg(CFG_HOLD_MS, 16'd20);
		repeat (20)
			push_word(1, 1, 0, 0, 0);
		push_word(0, 0, 0, 0, 0);
		wait_drained();

		// -- random phases with differing idle patterns
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			write_all(16'($urandom_range(0, 2)), 16'($urandom_range(0, 12)),
				16'($urandom_range(0, 3)));
			base = words_queued;
			while (words_queued - base < 50) begin
				if ($urandom_range(99) < 65)
					queue_session();
				else
					queue_noise($urandom_range(1, 8));
			end
			// sender holds off until every owed result is back
			wait_drained();
			while (words_queued - base < 100) begin
				if ($urandom_range(99) < 65)
					queue_session();
				else
					queue_noise($urandom_range(1, 8));
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
